// ===== rtl/core/vpp_pkg.sv =====
package vpp_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 1024;
  localparam int unsigned SCREEN_HEIGHT_DEF = 1024;

  localparam int unsigned COEF_W  = 9;
  localparam int unsigned ROW_W   = 3 * COEF_W;
  localparam int unsigned VTX_W   = 16;
  localparam int unsigned EYE_W   = 16;
  localparam int unsigned PROD_W  = COEF_W + VTX_W;
  localparam int unsigned ROT_W   = 28;
  localparam int unsigned NUM_W   = ROT_W + EYE_W;
  localparam int unsigned DEN_W   = 27;
  localparam int unsigned SCR_W   = 11;
  localparam int unsigned CIDX_W  = 8;
  localparam int unsigned CDATA_W = 32;

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(128);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(65536);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(33554432);
  localparam logic [EYE_W-1:0] EYE_RST  = EYE_W'(256);

  typedef enum logic [CIDX_W-1:0] {
    CFG_ROW0 = 8'd0,
    CFG_ROW1 = 8'd1,
    CFG_ROW2 = 8'd2,
    CFG_EYE  = 8'd3
  } cfg_idx_t;

endpackage

// ===== rtl/core/vertex_perspective_project.sv =====
// Channel  Dir  Payload
// in_      in   tdata: vertex_x, vertex_y, vertex_z
// out_     out  tdata: screen_x, screen_y; tuser: visible
// cfg_     in   index, data (matrix rows, eye distance)
//
// One item per cycle while out_ is not stalled. Stages: products, row sums, eye scale,
// the one-bit-per-stage divider (NQ = clog2(max screen size) + 1 bits), output register.
// Reset clears valid bits and loads the default matrix and eye distance.
// A stall on out_ holds the whole pipeline; in_tready follows it.
module vertex_perspective_project #(
  parameter int unsigned SCREEN_WIDTH  = vpp_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = vpp_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [47:0]                   in_tdata,   // vertex_x, vertex_y, vertex_z
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // screen_x, screen_y, zero pad
  output logic                          out_tuser,  // visible
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vpp_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [vpp_pkg::CDATA_W-1:0]   cfg_data
);
  import vpp_pkg::*;

  localparam int unsigned MAXS = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int unsigned NQ   = $clog2(MAXS) + 1;
  localparam int unsigned CW   = NQ + 3;
  localparam logic signed [CW-1:0] HALF_X = CW'(SCREEN_WIDTH / 2);
  localparam logic signed [CW-1:0] HALF_Y = CW'(SCREEN_HEIGHT / 2);
  localparam logic signed [CW-1:0] TOP_X  = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] TOP_Y  = CW'(SCREEN_HEIGHT - 1);

  logic [ROW_W-1:0] row_r [3];
  logic [EYE_W-1:0] eye_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]  <= ROW0_RST;
      row_r[1]  <= ROW1_RST;
      row_r[2]  <= ROW2_RST;
      eye_cfg_r <= EYE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW0: row_r[0]  <= cfg_data[ROW_W-1:0];
        CFG_ROW1: row_r[1]  <= cfg_data[ROW_W-1:0];
        CFG_ROW2: row_r[2]  <= cfg_data[ROW_W-1:0];
        CFG_EYE:  eye_cfg_r <= cfg_data[EYE_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 1: nine products
  logic signed [VTX_W-1:0]  vtx [3];
  logic signed [PROD_W-1:0] prod_r [3][3];
  logic signed [EYE_W-1:0]  eye1_r, eye2_r;
  logic v1_r, v2_r, v3_r;

  assign vtx[0] = in_tdata[15:0];
  assign vtx[1] = in_tdata[31:16];
  assign vtx[2] = in_tdata[47:32];

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [COEF_W-1:0] c;
      assign c = row_r[i][COEF_W*j +: COEF_W];
      always_ff @(posedge clk) begin
        if (en) prod_r[i][j] <= c * vtx[j];
      end
    end
  end

  // stage 2: row sums, eye distance added to the third row
  logic signed [ROT_W-1:0] p_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      eye1_r <= eye_cfg_r;
      p_r[0] <= ROT_W'(prod_r[0][0]) + ROT_W'(prod_r[0][1]) + ROT_W'(prod_r[0][2]);
      p_r[1] <= ROT_W'(prod_r[1][0]) + ROT_W'(prod_r[1][1]) + ROT_W'(prod_r[1][2]);
      p_r[2] <= ROT_W'(prod_r[2][0]) + ROT_W'(prod_r[2][1]) + ROT_W'(prod_r[2][2])
              + (ROT_W'(eye1_r) <<< 7);
      eye2_r <= eye1_r;
    end
  end

  // stage 3: scale by eye distance, visibility from the third row sum
  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic [DEN_W-1:0]        den_r;
  logic                    vis3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= NUM_W'(p_r[1]) * NUM_W'(eye2_r);
      ny_r   <= NUM_W'(p_r[0]) * NUM_W'(eye2_r);
      den_r  <= p_r[2][DEN_W-1:0];
      vis3_r <= (p_r[2] > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  logic [NQ-1:0] qx, qy;
  logic nx_neg, ny_neg, nx_ovf, ny_ovf;

  vpp_div #(.NQ(NQ)) u_div_x (
    .clk(clk), .en(en), .num(nx_r), .den(den_r),
    .q_mag(qx), .q_neg(nx_neg), .q_ovf(nx_ovf)
  );

  vpp_div #(.NQ(NQ)) u_div_y (
    .clk(clk), .en(en), .num(ny_r), .den(den_r),
    .q_mag(qy), .q_neg(ny_neg), .q_ovf(ny_ovf)
  );

  logic vd_r  [NQ+1];
  logic vis_r [NQ+1];

  always_ff @(posedge clk) begin
    if (en) vis_r[0] <= vis3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r[0] <= 1'b0;
    else if (en) vd_r[0] <= v3_r;
  end

  for (genvar s = 1; s <= NQ; s++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) vis_r[s] <= vis_r[s-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) vd_r[s] <= 1'b0;
      else if (en) vd_r[s] <= vd_r[s-1];
    end
  end

  function automatic logic [SCR_W-1:0] place(
    input logic [NQ-1:0] mag,
    input logic          neg,
    input logic          ovf,
    input logic signed [CW-1:0] half,
    input logic signed [CW-1:0] top
  );
    logic signed [CW-1:0] q;
    logic signed [CW-1:0] t;
    logic signed [CW-1:0] r;
    q = neg ? -CW'(mag) : CW'(mag);
    t = q + half;
    if (ovf)         r = neg ? '0 : top;
    else if (t < 0)  r = '0;
    else if (t >= top) r = top;
    else             r = t;
    return r[SCR_W-1:0];
  endfunction

  logic [SCR_W-1:0] sx_nxt, sy_nxt;
  logic [SCR_W-1:0] sx_r, sy_r;
  logic             vis_out_r;

  always_comb begin
    if (vis_r[NQ]) begin
      sx_nxt = place(qx, nx_neg, nx_ovf, HALF_X, TOP_X);
      sy_nxt = place(qy, ny_neg, ny_ovf, HALF_Y, TOP_Y);
    end else begin
      sx_nxt = '1;
      sy_nxt = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      vis_out_r <= vis_r[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vd_r[NQ];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, sy_r, sx_r};
  assign out_tuser  = vis_out_r;

endmodule

// ===== rtl/core/vpp_div.sv =====
module vpp_div #(
  parameter int unsigned NQ = 11
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [vpp_pkg::NUM_W-1:0] num,
  input  logic [vpp_pkg::DEN_W-1:0]  den,
  output logic [NQ-1:0]              q_mag,
  output logic                       q_neg,
  output logic                       q_ovf
);
  import vpp_pkg::*;

  logic [DEN_W-1:0] rem_r [NQ+1];
  logic [NQ-1:0]    low_r [NQ+1];
  logic [NQ-1:0]    q_r   [NQ+1];
  logic [DEN_W-1:0] den_r [NQ+1];
  logic             neg_r [NQ+1];
  logic             ovf_r [NQ+1];

  logic [NUM_W-1:0] mag;
  logic [NUM_W-NQ-1:0] hi;

  assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign hi  = mag[NUM_W-1:NQ];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= hi[DEN_W-1:0];
      low_r[0] <= mag[NQ-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      neg_r[0] <= num[NUM_W-1];
      ovf_r[0] <= (hi >= (NUM_W-NQ)'(den));
    end
  end

  for (genvar s = 1; s <= NQ; s++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem_r[s-1], low_r[s-1][NQ-1]};
    assign ge = (t >= {1'b0, den_r[s-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? DEN_W'(t - {1'b0, den_r[s-1]}) : t[DEN_W-1:0];
        low_r[s] <= {low_r[s-1][NQ-2:0], 1'b0};
        q_r[s]   <= {q_r[s-1][NQ-2:0], ge};
        den_r[s] <= den_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
      end
    end
  end

  assign q_mag = q_r[NQ];
  assign q_neg = neg_r[NQ];
  assign q_ovf = ovf_r[NQ];

endmodule

// ===== rtl/core/vpp_check.sv =====
module vpp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output changed while stalled");

  a_behind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[21:0] == 22'h3FFFFF)
    else $error("invisible item without -1 coordinates");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while pipeline held");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind vertex_perspective_project vpp_check u_vpp_check (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
);
